FILE: sv/smoothed_sensor_derivatives_unit_assert.svh
// assertion macros for the smoothed sensor derivatives unit
// used by the port checker, no other dependencies
`ifndef SMOOTHED_SENSOR_DERIVATIVES_UNIT_ASSERT_SVH
`define SMOOTHED_SENSOR_DERIVATIVES_UNIT_ASSERT_SVH

// same-cycle implication
`define SSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ssd_pkg.sv
// shared types, constants and codes of the smoothed sensor derivatives unit
// no dependencies
package ssd_pkg;

    localparam int SMP_W            = 16;
    localparam int CH_W             = 4;
    localparam int CFG_W            = 16;
    localparam int CFG_IDX_W        = 3;
    localparam int COUNT_W          = 5;
    localparam int DEF_MAX_CHANNELS = 16;

    // shared multiplier: signed operand a, non-negative 16-bit factor as operand b
    localparam int MUL_A_W = SMP_W + 17;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 3'd5;

    localparam logic [15:0]        RST_SMOOTH = 16'd32768;
    localparam logic [15:0]        RST_SCALE  = 16'd256;
    localparam logic [COUNT_W-1:0] RST_COUNT  = 5'd16;

    typedef enum logic [1:0] {
        KIND_RAW    = 2'd0,
        KIND_FIRST  = 2'd1,
        KIND_SECOND = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        MS_SMOOTH = 2'd0,
        MS_FIRST  = 2'd1,
        MS_SEC_A  = 2'd2,
        MS_SEC_B  = 2'd3
    } t_msel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_SMOOTH,
        ST_UPDATE,
        ST_FIRST_MUL,
        ST_FIRST_RND,
        ST_SEC_MUL_A,
        ST_SEC_MUL_B,
        ST_SEC_RND,
        ST_OUT_RAW,
        ST_OUT_FIRST,
        ST_OUT_SEC
    } t_state;

    typedef struct packed {
        logic [CH_W-1:0]         channel;
        logic signed [SMP_W-1:0] sample;
    } t_in;

    typedef struct packed {
        t_kind                   kind;
        logic [CH_W-1:0]         channel_out;
        logic signed [SMP_W-1:0] value;
        logic                    last;
    } t_out;

    typedef struct packed {
        logic [15:0]        smoothing_factor;
        logic [15:0]        derivative_scale;
        logic               emit_raw;
        logic               emit_first;
        logic               emit_second;
        logic [COUNT_W-1:0] channel_count;
    } t_cfg;

    typedef struct packed {
        logic  load_in;
        logic  load_hist;
        logic  mul_en;
        t_msel msel;
        logic  load_y;
        logic  load_d1;
        logic  load_d2;
        logic  out_load;
        t_kind out_kind;
        logic  out_last;
    } t_cmd;

    typedef struct packed {
        logic ch_ok;
        logic out_free;
    } t_sts;

endpackage

FILE: sv/ssd_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module ssd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/ssd_dp.sv
// datapath: channel history ram, shared multiplier, rounding, saturation, output register
// depends on ssd_pkg and ssd_ram
module ssd_dp #(
    parameter int MAX_CHANNELS = ssd_pkg::DEF_MAX_CHANNELS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ssd_pkg::t_in  i_in,
    input  ssd_pkg::t_cfg i_cfg,
    input  ssd_pkg::t_cmd i_cmd,
    output ssd_pkg::t_sts o_sts,
    output logic          o_out_valid,
    output ssd_pkg::t_out o_out,
    input  logic          i_out_stall
);
    import ssd_pkg::*;

    localparam int SW   = SMP_W;
    localparam int AW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CMPW = $clog2(MAX_CHANNELS + 1) + COUNT_W;

    localparam logic signed [PROD_W-1:0] HALF8  = PROD_W'(128);
    localparam logic signed [PROD_W-1:0] HALF16 = PROD_W'(32768);
    localparam logic signed [PROD_W-1:0] T_HI   = PROD_W'(64'sd1 <<< (SW + 15));
    localparam logic signed [PROD_W-1:0] T_LO   = -T_HI;
    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'((64'sd1 <<< (SW - 1)) - 64'sd1);
    localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);

    function automatic logic signed [SW-1:0] sat_sw(input logic signed [PROD_W-1:0] v);
        logic signed [SW-1:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[SW-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[SW-1:0];
        end else begin
            res = v[SW-1:0];
        end
        return res;
    endfunction

    logic [CH_W-1:0]           r_ch;
    logic signed [SW-1:0]      r_x;
    logic [AW-1:0]             r_addr;
    logic signed [SW-1:0]      r_y1;
    logic signed [SW-1:0]      r_y2;
    logic signed [SW-1:0]      r_y;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [SW-1:0]      r_d1;
    logic signed [SW-1:0]      r_d2;
    logic [MAX_CHANNELS-1:0]   r_vld;
    logic                      r_out_valid;
    t_out                      r_out;

    logic [AW+CH_W-1:0]        ch_ext;
    logic [AW-1:0]             in_addr;
    logic [2*SW-1:0]           rdata;
    logic signed [SW:0]        diff_smooth;
    logic signed [SW:0]        diff_first;
    logic signed [SW+2:0]      diff_second;
    logic signed [PROD_W-1:0]  t_clamp;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [PROD_W-1:0]  rnd8;
    logic signed [PROD_W-1:0]  rnd16;
    logic signed [SW-1:0]      n_y;
    t_out                      n_out;

    assign ch_ext  = {{AW{1'b0}}, i_in.channel};
    assign in_addr = ch_ext[AW-1:0];

    assign o_sts.ch_ok = ({1'b0, i_in.channel} < i_cfg.channel_count)
                      && (CMPW'(i_in.channel) < CMPW'(MAX_CHANNELS));
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    ssd_ram #(
        .WIDTH (2 * SW),
        .DEPTH (MAX_CHANNELS),
        .AW    (AW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_y),
        .i_waddr (r_addr),
        .i_wdata ({n_y, r_y1}),
        .i_re    (i_cmd.load_in),
        .i_raddr (in_addr),
        .o_rdata (rdata)
    );

    assign diff_smooth = {r_x[SW-1], r_x} - {r_y1[SW-1], r_y1};
    assign diff_first  = {r_y[SW-1], r_y} - {r_y2[SW-1], r_y2};
    assign diff_second = {{3{r_y[SW-1]}}, r_y} - {{2{r_y1[SW-1]}}, r_y1, 1'b0}
                       + {{3{r_y2[SW-1]}}, r_y2};

    // bound the scaled second difference; beyond it the result saturates anyway
    always_comb begin
        if (r_prod > T_HI) begin
            t_clamp = T_HI;
        end else if (r_prod < T_LO) begin
            t_clamp = T_LO;
        end else begin
            t_clamp = r_prod;
        end
    end

    always_comb begin
        case (i_cmd.msel)
            MS_SMOOTH: begin
                mul_a = {{(MUL_A_W-SW-1){diff_smooth[SW]}}, diff_smooth};
                mul_b = {1'b0, i_cfg.smoothing_factor};
            end
            MS_FIRST: begin
                mul_a = {{(MUL_A_W-SW-1){diff_first[SW]}}, diff_first};
                mul_b = {1'b0, i_cfg.derivative_scale};
            end
            MS_SEC_A: begin
                mul_a = {{(MUL_A_W-SW-3){diff_second[SW+2]}}, diff_second};
                mul_b = {1'b0, i_cfg.derivative_scale};
            end
            MS_SEC_B: begin
                mul_a = t_clamp[MUL_A_W-1:0];
                mul_b = {1'b0, i_cfg.derivative_scale};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign rnd8  = (r_prod + HALF8) >>> 8;
    assign rnd16 = (r_prod + HALF16) >>> 16;
    assign n_y   = r_y1 + rnd16[SW-1:0];

    always_comb begin
        n_out.kind        = i_cmd.out_kind;
        n_out.channel_out = r_ch;
        n_out.last        = i_cmd.out_last;
        case (i_cmd.out_kind)
            KIND_RAW:    n_out.value = r_x;
            KIND_FIRST:  n_out.value = r_d1;
            KIND_SECOND: n_out.value = r_d2;
            default:     n_out.value = r_x;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_ch   <= i_in.channel;
            r_x    <= i_in.sample;
            r_addr <= in_addr;
        end
        if (i_cmd.load_hist) begin
            r_y1 <= r_vld[r_addr] ? rdata[2*SW-1:SW] : '0;
            r_y2 <= r_vld[r_addr] ? rdata[SW-1:0] : '0;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_p;
        end
        if (i_cmd.load_y) begin
            r_y <= n_y;
        end
        if (i_cmd.load_d1) begin
            r_d1 <= sat_sw(rnd8);
        end
        if (i_cmd.load_d2) begin
            r_d2 <= sat_sw(rnd16);
        end
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_y) begin
                r_vld[r_addr] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: sv/ssd_ctrl.sv
// controller: sequences one sample through read, smoothing, derivatives and output beats
// depends on ssd_pkg
module ssd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ssd_pkg::t_cfg i_cfg,
    input  ssd_pkg::t_sts i_sts,
    output ssd_pkg::t_cmd o_cmd
);
    import ssd_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_raw_on;
    logic   r_first_on;
    logic   r_second_on;
    logic   n_raw_on;
    logic   n_first_on;
    logic   n_second_on;
    t_state out_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_raw_on    <= 1'b0;
            r_first_on  <= 1'b0;
            r_second_on <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_raw_on    <= n_raw_on;
            r_first_on  <= n_first_on;
            r_second_on <= n_second_on;
        end
    end

    assign out_start = r_raw_on ? ST_OUT_RAW : (r_first_on ? ST_OUT_FIRST : ST_OUT_SEC);
    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state        = r_state;
        n_raw_on       = r_raw_on;
        n_first_on     = r_first_on;
        n_second_on    = r_second_on;
        o_cmd.load_in  = 1'b0;
        o_cmd.load_hist = 1'b0;
        o_cmd.mul_en   = 1'b0;
        o_cmd.msel     = MS_SMOOTH;
        o_cmd.load_y   = 1'b0;
        o_cmd.load_d1  = 1'b0;
        o_cmd.load_d2  = 1'b0;
        o_cmd.out_load = 1'b0;
        o_cmd.out_kind = KIND_RAW;
        o_cmd.out_last = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_sts.ch_ok) begin
                    o_cmd.load_in = 1'b1;
                    n_raw_on    = i_cfg.emit_raw || (!i_cfg.emit_first && !i_cfg.emit_second);
                    n_first_on  = i_cfg.emit_first;
                    n_second_on = i_cfg.emit_second;
                    n_state     = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.load_hist = 1'b1;
                n_state = ST_SMOOTH;
            end
            ST_SMOOTH: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = MS_SMOOTH;
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.load_y = 1'b1;
                if (r_first_on) begin
                    n_state = ST_FIRST_MUL;
                end else if (r_second_on) begin
                    n_state = ST_SEC_MUL_A;
                end else begin
                    n_state = out_start;
                end
            end
            ST_FIRST_MUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = MS_FIRST;
                n_state = ST_FIRST_RND;
            end
            ST_FIRST_RND: begin
                o_cmd.load_d1 = 1'b1;
                n_state = r_second_on ? ST_SEC_MUL_A : out_start;
            end
            ST_SEC_MUL_A: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = MS_SEC_A;
                n_state = ST_SEC_MUL_B;
            end
            ST_SEC_MUL_B: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = MS_SEC_B;
                n_state = ST_SEC_RND;
            end
            ST_SEC_RND: begin
                o_cmd.load_d2 = 1'b1;
                n_state = out_start;
            end
            ST_OUT_RAW: begin
                o_cmd.out_kind = KIND_RAW;
                o_cmd.out_last = !r_first_on && !r_second_on;
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (r_first_on) begin
                        n_state = ST_OUT_FIRST;
                    end else if (r_second_on) begin
                        n_state = ST_OUT_SEC;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_OUT_FIRST: begin
                o_cmd.out_kind = KIND_FIRST;
                o_cmd.out_last = !r_second_on;
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = r_second_on ? ST_OUT_SEC : ST_IDLE;
                end
            end
            ST_OUT_SEC: begin
                o_cmd.out_kind = KIND_SECOND;
                o_cmd.out_last = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/smoothed_sensor_derivatives_unit.sv
// top level of the smoothed sensor derivatives unit: configuration registers,
// controller and datapath; depends on ssd_pkg, ssd_ctrl, ssd_dp, ssd_ram
//
// usage
// - input channel: one beat carries a channel number and a signed sample; a beat is
//   taken when i_in_valid is high and o_in_stall is low
// - output channel: each accepted sample gives one to three beats (raw, first
//   difference, second difference, as enabled), the final one flagged last; a beat
//   moves when o_out_valid is high and i_out_stall is low
// - a sample for a channel at or above the channel count or MAX_CHANNELS is taken and dropped
// - one sample at a time through a single shared 33x17 multiplier: history read,
//   smoothing, first difference and second difference as enabled, then the output
//   beats, then back in idle
// - the last beat sits in the output register while the next sample is taken
// - a stalled receiver holds the output register and the sequencer waits for it
// - reset clears state and history valid bits and loads the config defaults; history entries read as zero until written
// - config writes are taken at any edge with i_cfg_we high, meant for idle periods
module smoothed_sensor_derivatives_unit #(
    parameter int MAX_CHANNELS = ssd_pkg::DEF_MAX_CHANNELS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  ssd_pkg::t_in                      i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output ssd_pkg::t_out                     o_out_data,
    input  logic                              i_cfg_we,
    input  logic [ssd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ssd_pkg::CFG_W-1:0]         i_cfg_data
);
    import ssd_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.smoothing_factor <= RST_SMOOTH;
            r_cfg.derivative_scale <= RST_SCALE;
            r_cfg.emit_raw         <= 1'b1;
            r_cfg.emit_first       <= 1'b1;
            r_cfg.emit_second      <= 1'b0;
            r_cfg.channel_count    <= RST_COUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SMOOTH: r_cfg.smoothing_factor <= i_cfg_data[15:0];
                CFG_SCALE:  r_cfg.derivative_scale <= i_cfg_data[15:0];
                CFG_RAW:    r_cfg.emit_raw         <= i_cfg_data[0];
                CFG_FIRST:  r_cfg.emit_first       <= i_cfg_data[0];
                CFG_SECOND: r_cfg.emit_second      <= i_cfg_data[0];
                CFG_COUNT:  r_cfg.channel_count    <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ssd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_cfg      (r_cfg),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ssd_dp #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in_data),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

FILE: sv/ssd_chk.sv
// port checker for the smoothed sensor derivatives unit, bound to the top level
// depends on ssd_pkg and smoothed_sensor_derivatives_unit_assert.svh
`include "smoothed_sensor_derivatives_unit_assert.svh"

module ssd_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input ssd_pkg::t_out                 o_out_data
);
    import ssd_pkg::*;

    // stalled beat holds
    `SSD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled beat changed")

    // no new sample while beats of the current one are pending
    `SSD_ASSERT_IMP(a_busy, i_clk, i_rst_n, o_out_valid && !o_out_data.last, o_in_stall, "sample taken mid burst")

    // next beat of a burst follows at once, same channel, later kind
    `SSD_ASSERT_NXT(a_burst, i_clk, i_rst_n, o_out_valid && !o_out_data.last && !i_out_stall, o_out_valid && (o_out_data.channel_out == $past(o_out_data.channel_out)) && (o_out_data.kind > $past(o_out_data.kind)), "burst order broken")

    // second difference always closes a burst
    `SSD_ASSERT_IMP(a_sec_last, i_clk, i_rst_n, o_out_valid && (o_out_data.kind == KIND_SECOND), o_out_data.last, "second difference not last")

endmodule

bind smoothed_sensor_derivatives_unit ssd_chk u_chk (.*);

FILE: bench/ssd_result_checker.sv
// result checker for the smoothed sensor derivatives unit: watches the config port and both
// channels, predicts the output beats of every sample and compares them; depends on ssd_pkg
module ssd_result_checker
    import ssd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in                  i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out                 i_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_pending,
    output int                   o_errors,
    output int                   o_beats,
    output int                   o_dropped
);

    longint             eps;
    longint             scale;
    logic               emit_raw;
    logic               emit_first;
    logic               emit_second;
    logic [COUNT_W-1:0] ch_count;

    longint newest_y [DEF_MAX_CHANNELS];
    longint older_y  [DEF_MAX_CHANNELS];

    t_out due_outputs [$];

    initial begin
        o_pending = 0;
        o_errors  = 0;
        o_beats   = 0;
        o_dropped = 0;
    end

    function automatic longint round_half_up(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_sample(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    task automatic smooth_and_differentiate(input t_in beat);
        t_out   res [3];
        int     n;
        longint x;
        longint y;
        longint y1;
        longint y2;
        logic   raw_on;
        if (beat.channel >= ch_count) begin
            o_dropped++;
            return;
        end
        x  = longint'($signed(beat.sample));
        y1 = newest_y[beat.channel];
        y2 = older_y[beat.channel];
        y  = y1 + round_half_up((x - y1) * eps, 16);
        n  = 0;
        raw_on = emit_raw || (!emit_first && !emit_second);
        if (raw_on) begin
            res[n] = '{kind: KIND_RAW, channel_out: beat.channel, value: beat.sample, last: 1'b0};
            n++;
        end
        if (emit_first) begin
            res[n] = '{kind: KIND_FIRST, channel_out: beat.channel,
                       value: SMP_W'(clamp_sample(round_half_up((y - y2) * scale, 8))),
                       last: 1'b0};
            n++;
        end
        if (emit_second) begin
            res[n] = '{kind: KIND_SECOND, channel_out: beat.channel,
                       value: SMP_W'(clamp_sample(
                           round_half_up((y - 2 * y1 + y2) * scale * scale, 16))),
                       last: 1'b0};
            n++;
        end
        older_y[beat.channel]  = y1;
        newest_y[beat.channel] = y;
        res[n-1].last = 1'b1;
        for (int k = 0; k < n; k++)
            due_outputs.push_back(res[k]);
    endtask

    always @(posedge i_clk) begin
        t_out exp_beat;
        if (!i_rst_n) begin
            eps         = longint'(RST_SMOOTH);
            scale       = longint'(RST_SCALE);
            emit_raw    = 1'b1;
            emit_first  = 1'b1;
            emit_second = 1'b0;
            ch_count    = RST_COUNT;
            for (int c = 0; c < DEF_MAX_CHANNELS; c++) begin
                newest_y[c] = 0;
                older_y[c]  = 0;
            end
            due_outputs.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SMOOTH: eps         = longint'(i_cfg_data);
                    CFG_SCALE:  scale       = longint'(i_cfg_data);
                    CFG_RAW:    emit_raw    = i_cfg_data[0];
                    CFG_FIRST:  emit_first  = i_cfg_data[0];
                    CFG_SECOND: emit_second = i_cfg_data[0];
                    CFG_COUNT:  ch_count    = i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                o_beats++;
                if (due_outputs.size() == 0) begin
                    o_errors++;
                    $display("%0t unexpected beat: kind %0d ch %0d value %0d last %0d",
                             $time, i_out_data.kind, i_out_data.channel_out,
                             i_out_data.value, i_out_data.last);
                end else begin
                    exp_beat = due_outputs.pop_front();
                    if (i_out_data.kind !== exp_beat.kind
                            || i_out_data.channel_out !== exp_beat.channel_out
                            || i_out_data.value !== exp_beat.value
                            || i_out_data.last !== exp_beat.last) begin
                        o_errors++;
                        $display("%0t mismatch: expected kind %0d ch %0d value %0d last %0d",
                                 $time, exp_beat.kind, exp_beat.channel_out,
                                 exp_beat.value, exp_beat.last);
                        $display("%0t           actual   kind %0d ch %0d value %0d last %0d",
                                 $time, i_out_data.kind, i_out_data.channel_out,
                                 i_out_data.value, i_out_data.last);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                smooth_and_differentiate(i_in_data);
        end
        o_pending <= due_outputs.size();
    end

endmodule

FILE: bench/tb_smoothed_sensor_derivatives_unit.sv
// testbench top for the smoothed sensor derivatives unit: clock, reset, config writes,
// sample stimulus and verdict; depends on ssd_pkg, ssd_result_checker and the unit itself
module tb_smoothed_sensor_derivatives_unit;
    import ssd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 3'd7;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in                  i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out                 o_out_data;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    int pending;
    int errors;
    int beats;
    int dropped;
    int cycles     = 0;
    int sent       = 0;
    int settings   = 0;
    int gap_odds   = 0;
    int stall_odds = 0;
    int cur_count  = 16;

    logic signed [SMP_W-1:0] wave [DEF_MAX_CHANNELS];

    smoothed_sensor_derivatives_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    ssd_result_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (pending),
        .o_errors    (errors),
        .o_beats     (beats),
        .o_dropped   (dropped)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("tb_smoothed_sensor_derivatives_unit NOT OK");
            $finish;
        end
    end

    // receiver stall bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_sample(input logic [CH_W-1:0] ch, input logic signed [SMP_W-1:0] smp);
        i_in_valid <= 1'b1;
        i_in_data  <= '{channel: ch, sample: smp};
        do @(posedge i_clk); while (o_in_stall);
        sent++;
        if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // unused upper data bits are randomized on the narrow registers
    task automatic program_cfg(input int eps, input int scale, input bit raw, input bit first,
                               input bit second, input int count);
        write_reg(CFG_SMOOTH, CFG_W'(eps));
        write_reg(CFG_SCALE, CFG_W'(scale));
        write_reg(CFG_RAW, {15'($urandom), raw});
        write_reg(CFG_FIRST, {15'($urandom), first});
        write_reg(CFG_SECOND, {15'($urandom), second});
        write_reg(CFG_COUNT, {11'($urandom), 5'(count)});
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        cur_count = count;
        settings++;
    endtask

    task automatic run_random_phase(input int items);
        int                      n_used;
        int                      ch;
        int                      pick;
        int                      w;
        logic signed [SMP_W-1:0] smp;
        n_used = (cur_count > DEF_MAX_CHANNELS) ? DEF_MAX_CHANNELS : cur_count;
        for (int k = 0; k < items; k++) begin
            if (n_used > 0 && $urandom_range(0, 9) != 0)
                ch = $urandom_range(0, n_used - 1);
            else
                ch = $urandom_range(0, DEF_MAX_CHANNELS - 1);
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                smp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            end else if (pick < 6) begin
                // slow drifting signal per channel
                w = int'(wave[ch]) + int'($urandom_range(0, 1024)) - 512;
                if (w > 32767)
                    w = 32767;
                if (w < -32768)
                    w = -32768;
                smp = w[SMP_W-1:0];
            end else begin
                smp = SMP_W'($urandom);
            end
            wave[ch] = smp;
            send_sample(ch[CH_W-1:0], smp);
            if ($urandom_range(0, 39) == 0)
                drain_and_settle();
        end
    endtask

    initial begin
        int eps;
        int scale;
        int count;
        for (int c = 0; c < DEF_MAX_CHANNELS; c++)
            wave[c] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: raw and first difference
        gap_odds   = 3;
        stall_odds = 4;
        send_sample(4'd0, 16'sh7FFF);
        send_sample(4'd0, 16'sh8000);
        send_sample(4'd15, 16'sh7FFF);
        send_sample(4'd15, -16'sd1);
        send_sample(4'd7, 16'sd1);
        drain_and_settle();

        // everything on, largest factors, full swings to saturate
        program_cfg(65535, 65535, 1'b1, 1'b1, 1'b1, 16);
        send_sample(4'd2, 16'sh7FFF);
        send_sample(4'd2, 16'sh8000);
        send_sample(4'd2, 16'sh7FFF);
        send_sample(4'd2, 16'sh8000);
        send_sample(4'd9, 16'sd0);
        drain_and_settle();

        // writes to indexes past the list, then all outputs off so raw is forced
        write_reg(CFG_UNUSED_A, 16'hFFFF);
        write_reg(CFG_UNUSED_B, 16'h0000);
        program_cfg(0, 0, 1'b0, 1'b0, 1'b0, 16);
        send_sample(4'd4, 16'sh8000);
        send_sample(4'd4, 16'sd12345);
        drain_and_settle();

        // second difference only, three channels in use
        program_cfg(1, 256, 1'b0, 1'b0, 1'b1, 3);
        send_sample(4'd2, 16'sh8000);
        send_sample(4'd3, 16'sd77);
        send_sample(4'd15, -16'sd77);
        send_sample(4'd0, 16'sd100);
        drain_and_settle();

        // channel count zero drops everything
        program_cfg(32768, 512, 1'b1, 1'b0, 1'b1, 0);
        send_sample(4'd0, 16'sd5);
        send_sample(4'd15, 16'sd5);
        drain_and_settle();

        // count above the channel limit
        program_cfg(40000, 300, 1'b0, 1'b1, 1'b0, 31);
        send_sample(4'd15, 16'sh8000);
        send_sample(4'd15, 16'sh7FFF);
        drain_and_settle();

        for (int p = 0; p < 6; p++) begin
            case ($urandom_range(0, 3))
                0:       eps = 0;
                1:       eps = 65535;
                2:       eps = $urandom_range(1024, 16384);
                default: eps = $urandom_range(0, 65535);
            endcase
            case ($urandom_range(0, 3))
                0:       scale = 65535;
                1:       scale = $urandom_range(0, 1024);
                2:       scale = 256;
                default: scale = $urandom_range(0, 65535);
            endcase
            count = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 31)
                                                : $urandom_range(1, 16);
            case ($urandom_range(0, 2))
                0:       gap_odds = 0;
                1:       gap_odds = 2;
                default: gap_odds = 6;
            endcase
            case ($urandom_range(0, 2))
                0:       stall_odds = 0;
                1:       stall_odds = 2;
                default: stall_odds = 6;
            endcase
            program_cfg(eps, scale, 1'($urandom), 1'($urandom), 1'($urandom), count);
            run_random_phase(45);
            drain_and_settle();
        end

        // closing stretch at full rate on both sides
        gap_odds   = 0;
        stall_odds = 0;
        program_cfg($urandom_range(0, 65535), $urandom_range(0, 2048), 1'b1, 1'b1, 1'b1, 16);
        run_random_phase(40);
        drain_and_settle();

        $display("sent %0d samples (%0d dropped on unused channels), checked %0d result beats",
                 sent, dropped, beats);
        $display("across %0d register settings with random gaps and stalls", settings + 1);
        if (errors == 0)
            $display("tb_smoothed_sensor_derivatives_unit OK");
        else
            $display("tb_smoothed_sensor_derivatives_unit NOT OK");
        $finish;
    end

endmodule

FILE: smoothed_sensor_derivatives_unit.f
+incdir+sv
sv/ssd_pkg.sv
sv/ssd_ram.sv
sv/ssd_dp.sv
sv/ssd_ctrl.sv
sv/smoothed_sensor_derivatives_unit.sv
sv/ssd_chk.sv
bench/ssd_result_checker.sv
bench/tb_smoothed_sensor_derivatives_unit.sv
